// ----- design/prv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prv_pkg
// Shared types, widths and constants of the cursor repulsion velocity update.
// ----------------------------------------------------------------------------
package prv_pkg;

  // Field widths
  localparam int COORD_WIDTH    = 24;
  localparam int STRENGTH_WIDTH = 13;
  localparam int RADIUS_WIDTH   = 16;
  localparam int TIME_WIDTH     = 16;

  // Strength of 1.0 in Q5.8 enables the push
  localparam int MIN_STRENGTH = 256;

  // 500000 * 60 folded into one gain, Q.16 alignment of the quotient
  localparam int FORCE_SCALE = 30000000;
  localparam int SCALE_WIDTH = 25;
  localparam int FRAC_SHIFT  = 16;

  // Quotient bits kept; magnitudes above 2^40 saturate
  localparam int QUOT_WIDTH    = 41;
  localparam int MAG_LIMIT_BIT = 40;
  localparam int SUM_WIDTH     = QUOT_WIDTH + 2;

  // Datapath widths
  localparam int ABS_WIDTH  = COORD_WIDTH + 1;
  localparam int SQ_WIDTH   = 2 * ABS_WIDTH;
  localparam int ROOT_WIDTH = ABS_WIDTH;
  localparam int RSQ_WIDTH  = 2 * RADIUS_WIDTH;
  localparam int ST_WIDTH   = STRENGTH_WIDTH + TIME_WIDTH;
  localparam int GAIN_WIDTH = ST_WIDTH + SCALE_WIDTH;
  localparam int PROD_WIDTH = GAIN_WIDTH + ABS_WIDTH;
  localparam int NUM_WIDTH  = PROD_WIDTH + FRAC_SHIFT;
  localparam int DD_WIDTH   = SQ_WIDTH + ROOT_WIDTH;
  localparam int DEN_WIDTH  = DD_WIDTH + RSQ_WIDTH;

  // Pipeline timing, counted from the input register stage
  localparam int MUL_LAT    = 2;
  localparam int DEN_READY  = 3 * MUL_LAT + 1 + ROOT_WIDTH;
  localparam int NUM_DELAY  = DEN_READY - 3 * MUL_LAT;
  localparam int SQ_DELAY   = ROOT_WIDTH;
  localparam int RSQ_DELAY  = MUL_LAT + 1 + ROOT_WIDTH;
  localparam int DIV_LAT    = QUOT_WIDTH + 1;
  localparam int SIDE_DELAY = DEN_READY + DIV_LAT;
  localparam int LATENCY    = SIDE_DELAY + 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] node_x;
    logic signed [COORD_WIDTH-1:0] node_y;
    logic signed [COORD_WIDTH-1:0] cursor_x;
    logic signed [COORD_WIDTH-1:0] cursor_y;
    logic signed [COORD_WIDTH-1:0] vel_x;
    logic signed [COORD_WIDTH-1:0] vel_y;
    logic [RADIUS_WIDTH-1:0]       node_radius;
    logic [TIME_WIDTH-1:0]         frame_time;
  } node_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] new_vel_x;
    logic signed [COORD_WIDTH-1:0] new_vel_y;
    logic                          push_applied;
    logic                          saturated;
  } result_t;

endpackage
`default_nettype wire

// ----- design/point_repulsion_velocity_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_repulsion_velocity_update
// Inverse-square push of a node's velocity away from the cursor.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_data is the repulsion strength (Q5.8), written when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write it
//   only while no transaction is in flight.
//   Input: a node transaction is taken on a clock edge with start high and
//   busy low. busy stays low, so one node can enter every cycle.
//   Output: done is high for one cycle with the result on result. The
//   receiver cannot stall; results come in input order.
//   Throughput is one node per clock. The latency is set by the pipelined
//   square root stages (one per root bit), the multiplier stages and the
//   41 quotient stages of the divider.
//   Reset clears the strength register and all valid bits in flight.
// ----------------------------------------------------------------------------
module point_repulsion_velocity_update (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prv_pkg::STRENGTH_WIDTH-1:0]    cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  prv_pkg::node_t                        node,
  output logic                                  done,
  output prv_pkg::result_t                      result
);

  localparam int W   = prv_pkg::COORD_WIDTH;
  localparam int AXW = prv_pkg::ABS_WIDTH;
  localparam int QW  = prv_pkg::QUOT_WIDTH;
  localparam int SW  = prv_pkg::SUM_WIDTH;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] MAG_LIMIT = QW'(1) << prv_pkg::MAG_LIMIT_BIT;
  localparam logic [prv_pkg::SCALE_WIDTH-1:0] SCALE =
    prv_pkg::SCALE_WIDTH'(prv_pkg::FORCE_SCALE);

  typedef struct packed {
    logic                valid;
    logic                en;
    logic                zero_d;
    logic                zero_r;
    logic                nz_x;
    logic                nz_y;
    logic                neg_x;
    logic                neg_y;
    logic signed [W-1:0] vel_x;
    logic signed [W-1:0] vel_y;
  } side_t;

  // Strength register
  logic [prv_pkg::STRENGTH_WIDTH-1:0] strength;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= '0;
    end else if (cfg_valid && cfg_ready) begin
      strength <= cfg_data;
    end
  end

  // Input stage: offsets and magnitudes
  logic signed [AXW-1:0] dx, dy;
  logic [AXW-1:0]        ax, ay;
  logic [prv_pkg::RADIUS_WIDTH-1:0]   rad;
  logic [prv_pkg::TIME_WIDTH-1:0]     ftime;
  logic [prv_pkg::STRENGTH_WIDTH-1:0] str;
  side_t                 side_a;

  assign dx = $signed({node.node_x[W-1], node.node_x})
            - $signed({node.cursor_x[W-1], node.cursor_x});
  assign dy = $signed({node.node_y[W-1], node.node_y})
            - $signed({node.cursor_y[W-1], node.cursor_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.valid <= 1'b0;
    end else begin
      side_a.valid <= start && !busy;
    end
    ax           <= dx[AXW-1] ? AXW'(-dx) : AXW'(dx);
    ay           <= dy[AXW-1] ? AXW'(-dy) : AXW'(dy);
    rad          <= node.node_radius;
    ftime        <= node.frame_time;
    str          <= strength;
    side_a.en    <= strength >= prv_pkg::STRENGTH_WIDTH'(prv_pkg::MIN_STRENGTH);
    side_a.zero_d <= (dx == '0) && (dy == '0);
    side_a.zero_r <= node.node_radius == '0;
    side_a.nz_x  <= dx != '0;
    side_a.nz_y  <= dy != '0;
    side_a.neg_x <= dx[AXW-1];
    side_a.neg_y <= dy[AXW-1];
    side_a.vel_x <= node.vel_x;
    side_a.vel_y <= node.vel_y;
  end

  // Squares, radius squared, strength times time
  logic [prv_pkg::SQ_WIDTH-1:0]   sq_x, sq_y, d2;
  logic [prv_pkg::RSQ_WIDTH-1:0]  rsq;
  logic [prv_pkg::ST_WIDTH-1:0]   st;

  prv_mul #(.AW(AXW), .BW(AXW)) u_sqx (.clk(clk), .a(ax), .b(ax), .p(sq_x));
  prv_mul #(.AW(AXW), .BW(AXW)) u_sqy (.clk(clk), .a(ay), .b(ay), .p(sq_y));
  prv_mul #(.AW(prv_pkg::RADIUS_WIDTH), .BW(prv_pkg::RADIUS_WIDTH)) u_rsq (
    .clk(clk), .a(rad), .b(rad), .p(rsq)
  );
  prv_mul #(.AW(prv_pkg::STRENGTH_WIDTH), .BW(prv_pkg::TIME_WIDTH)) u_st (
    .clk(clk), .a(str), .b(ftime), .p(st)
  );

  // Squared distance
  always_ff @(posedge clk) begin
    d2 <= sq_x + sq_y;
  end

  // Numerators: gain * |offset|, delayed to meet the denominator
  logic [AXW-1:0]                  ax_d, ay_d;
  logic [prv_pkg::GAIN_WIDTH-1:0]  gain;
  logic [prv_pkg::PROD_WIDTH-1:0]  pr_x, pr_y, pr_x_d, pr_y_d;

  prv_dly #(.WIDTH(AXW), .DEPTH(2 * prv_pkg::MUL_LAT)) u_axd (
    .clk(clk), .rst(rst), .din(ax), .dout(ax_d)
  );
  prv_dly #(.WIDTH(AXW), .DEPTH(2 * prv_pkg::MUL_LAT)) u_ayd (
    .clk(clk), .rst(rst), .din(ay), .dout(ay_d)
  );
  prv_mul #(.AW(prv_pkg::ST_WIDTH), .BW(prv_pkg::SCALE_WIDTH)) u_gain (
    .clk(clk), .a(st), .b(SCALE), .p(gain)
  );
  prv_mul #(.AW(prv_pkg::GAIN_WIDTH), .BW(AXW)) u_prx (
    .clk(clk), .a(gain), .b(ax_d), .p(pr_x)
  );
  prv_mul #(.AW(prv_pkg::GAIN_WIDTH), .BW(AXW)) u_pry (
    .clk(clk), .a(gain), .b(ay_d), .p(pr_y)
  );
  prv_dly #(.WIDTH(prv_pkg::PROD_WIDTH), .DEPTH(prv_pkg::NUM_DELAY)) u_nxd (
    .clk(clk), .rst(rst), .din(pr_x), .dout(pr_x_d)
  );
  prv_dly #(.WIDTH(prv_pkg::PROD_WIDTH), .DEPTH(prv_pkg::NUM_DELAY)) u_nyd (
    .clk(clk), .rst(rst), .din(pr_y), .dout(pr_y_d)
  );

  // Denominator: d2 * floor(sqrt(d2)) * r^2
  logic [prv_pkg::ROOT_WIDTH-1:0] root;
  logic [prv_pkg::SQ_WIDTH-1:0]   d2_d;
  logic [prv_pkg::RSQ_WIDTH-1:0]  rsq_d;
  logic [prv_pkg::DD_WIDTH-1:0]   dd;
  logic [prv_pkg::DEN_WIDTH-1:0]  den;

  prv_sqrt #(.RW(prv_pkg::ROOT_WIDTH)) u_sqrt (.clk(clk), .rad(d2), .root(root));
  prv_dly #(.WIDTH(prv_pkg::SQ_WIDTH), .DEPTH(prv_pkg::SQ_DELAY)) u_d2d (
    .clk(clk), .rst(rst), .din(d2), .dout(d2_d)
  );
  prv_dly #(.WIDTH(prv_pkg::RSQ_WIDTH), .DEPTH(prv_pkg::RSQ_DELAY)) u_rsqd (
    .clk(clk), .rst(rst), .din(rsq), .dout(rsq_d)
  );
  prv_mul #(.AW(prv_pkg::SQ_WIDTH), .BW(prv_pkg::ROOT_WIDTH)) u_dd (
    .clk(clk), .a(d2_d), .b(root), .p(dd)
  );
  prv_mul #(.AW(prv_pkg::DD_WIDTH), .BW(prv_pkg::RSQ_WIDTH)) u_den (
    .clk(clk), .a(dd), .b(rsq_d), .p(den)
  );

  // Push magnitudes
  logic [prv_pkg::NUM_WIDTH-1:0] num_x, num_y;
  logic [QW-1:0]                 mag_x, mag_y;
  logic                          ovf_x, ovf_y;

  assign num_x = {pr_x_d, {prv_pkg::FRAC_SHIFT{1'b0}}};
  assign num_y = {pr_y_d, {prv_pkg::FRAC_SHIFT{1'b0}}};

  prv_div #(.NW(prv_pkg::NUM_WIDTH), .DW(prv_pkg::DEN_WIDTH), .QW(QW)) u_divx (
    .clk(clk), .num(num_x), .den(den), .quot(mag_x), .ovf(ovf_x)
  );
  prv_div #(.NW(prv_pkg::NUM_WIDTH), .DW(prv_pkg::DEN_WIDTH), .QW(QW)) u_divy (
    .clk(clk), .num(num_y), .den(den), .quot(mag_y), .ovf(ovf_y)
  );

  // Side data travels with the transaction
  side_t side_z;

  prv_dly #(.WIDTH($bits(side_t)), .DEPTH(prv_pkg::SIDE_DELAY)) u_side (
    .clk(clk), .rst(rst), .din(side_a), .dout(side_z)
  );

  // Signed add with clamp; MSB of the return value flags saturation
  function automatic logic [W:0] push_sum(
    input logic signed [W-1:0] vel,
    input logic                neg,
    input logic [QW-1:0]       mag,
    input logic                ovf
  );
    logic signed [SW-1:0] s;
    logic [W:0]           r;
    s = neg ? SW'(vel) - $signed({2'b00, mag}) : SW'(vel) + $signed({2'b00, mag});
    if (ovf || mag > MAG_LIMIT) begin
      r = {1'b1, neg ? VMIN : VMAX};
    end else if (s > SW'(VMAX)) begin
      r = {1'b1, VMAX};
    end else if (s < SW'(VMIN)) begin
      r = {1'b1, VMIN};
    end else begin
      r = {1'b0, W'(s)};
    end
    return r;
  endfunction

  // Final selection
  logic [W:0]       sum_x, sum_y;
  prv_pkg::result_t res_next;

  assign sum_x = push_sum(side_z.vel_x, side_z.neg_x, mag_x, ovf_x);
  assign sum_y = push_sum(side_z.vel_y, side_z.neg_y, mag_y, ovf_y);

  always_comb begin
    res_next.new_vel_x    = side_z.vel_x;
    res_next.new_vel_y    = side_z.vel_y;
    res_next.push_applied = side_z.en;
    res_next.saturated    = 1'b0;
    priority if (!side_z.en) begin
      res_next.saturated = 1'b0;
    end else if (side_z.zero_d) begin
      res_next.saturated = 1'b1;
    end else if (side_z.zero_r) begin
      if (side_z.nz_x) res_next.new_vel_x = side_z.neg_x ? VMIN : VMAX;
      if (side_z.nz_y) res_next.new_vel_y = side_z.neg_y ? VMIN : VMAX;
      res_next.saturated = 1'b1;
    end else begin
      res_next.new_vel_x = sum_x[W-1:0];
      res_next.new_vel_y = sum_y[W-1:0];
      res_next.saturated = sum_x[W] | sum_y[W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_z.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule
`default_nettype wire

// ----- design/prv_dly.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prv_dly
// Fixed-length shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module prv_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap [DEPTH];

  // Shift one tap per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) tap[k] <= '0;
    end else begin
      tap[0] <= din;
      for (int k = 1; k < DEPTH; k++) tap[k] <= tap[k-1];
    end
  end

  assign dout = tap[DEPTH-1];

endmodule
`default_nettype wire

// ----- design/prv_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prv_mul
// Two-stage unsigned multiplier: 32-bit slices of a times b, then the sum.
// ----------------------------------------------------------------------------
module prv_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NC = (AW + 31) / 32;
  localparam int EW = NC * 32;
  localparam int PW = 32 + BW;
  localparam int SW = EW + BW;

  logic [EW-1:0] a_ext;
  logic [PW-1:0] pp [NC];
  logic [SW-1:0] acc;

  assign a_ext = EW'(a);

  // Partial products, one slice each
  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) pp[c] <= a_ext[c*32 +: 32] * b;
  end

  // Align and add the partial products
  always_comb begin
    acc = '0;
    for (int c = 0; c < NC; c++) acc = acc + (SW'(pp[c]) << (32 * c));
  end

  always_ff @(posedge clk) begin
    p <= acc[AW+BW-1:0];
  end

endmodule
`default_nettype wire

// ----- design/prv_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prv_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module prv_sqrt #(
  parameter int RW = 25
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int RADW = 2 * RW;
  localparam int TW   = RADW + 1;

  logic [RADW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [RADW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [TW-1:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      rem_q[k]  <= take ? RADW'(TW'(rem_in) - trial) : rem_in;
      root_q[k] <= root_in | (RW'(take) << B);
    end
  end

  assign root = root_q[RW-1];

endmodule
`default_nettype wire

// ----- design/prv_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prv_div
// Pipelined restoring divider with a bounded quotient and overflow flag.
// ----------------------------------------------------------------------------
module prv_div #(
  parameter int NW = 95,
  parameter int DW = 107,
  parameter int QW = 41
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot,
  output logic          ovf
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  // Entry: quotient of 2^QW or more is flagged up front
  always_ff @(posedge clk) begin
    rem_q[0] <= num;
    den_q[0] <= den;
    quo_q[0] <= '0;
    ovf_q[0] <= CW'(num >> QW) >= CW'(den);
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [CW-1:0] sh;
    logic          take;

    assign sh   = CW'(den_q[k]) << B;
    assign take = CW'(rem_q[k]) >= sh;

    always_ff @(posedge clk) begin
      rem_q[k+1] <= take ? NW'(CW'(rem_q[k]) - sh) : rem_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_q[k] | (QW'(take) << B);
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign quot = quo_q[QW];
  assign ovf  = ovf_q[QW];

endmodule
`default_nettype wire

// ----- design/prv_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prv_checker
// Port-level checks of the repulsion velocity update, bound to the top level.
// ----------------------------------------------------------------------------
module prv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input prv_pkg::result_t                   result
);

  // Fully pipelined: never refuses a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Reset empties the pipeline
  a_rst_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(prv_pkg::LATENCY) done)
    else $error("result missing at fixed latency");

  // Saturation only when a push was taken
  a_sat_needs_push: assert property (@(posedge clk) disable iff (rst)
    done && !result.push_applied |-> !result.saturated)
    else $error("saturated without push");

endmodule

bind point_repulsion_velocity_update prv_checker u_prv_checker (.*);
`default_nettype wire
